// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the resampler RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- rtl/ugpr_pkg.sv -----
// Shared types for the uniform grid path resampler.
// No dependencies; used by the serial units and the top level.
package ugpr_pkg;

  // Status of a multi-cycle serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } ugpr_unit_sts_t;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } ugpr_state_e;

endpackage

// ----- rtl/ugpr_point_if.sv -----
// Valid/ready channel carrying one timed path point.
// No dependencies.
interface ugpr_point_if #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic        [TIME_WIDTH-1:0]  point_time;
  logic                          path_start;

  modport source (output valid, point_x, point_y, point_time, path_start, input ready);
  modport sink   (input valid, point_x, point_y, point_time, path_start, output ready);
endinterface

// ----- rtl/ugpr_sample_if.sv -----
// Valid/ready channel carrying one resampled grid point.
// No dependencies.
interface ugpr_sample_if #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] sample_x;
  logic signed [COORD_WIDTH-1:0] sample_y;
  logic        [TIME_WIDTH-1:0]  sample_time;
  logic                          last_of_run;
  logic                          truncated;

  modport source (output valid, sample_x, sample_y, sample_time, last_of_run, truncated,
                  input ready);
  modport sink   (input valid, sample_x, sample_y, sample_time, last_of_run, truncated,
                  output ready);
endinterface

// ----- rtl/ugpr_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ugpr_pkg for the unit status struct.
module ugpr_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [WIDTH-1:0]        dividend_i,
  input  logic [WIDTH-1:0]        divisor_i,
  output logic [WIDTH-1:0]        quotient_o,
  output logic [WIDTH-1:0]        remainder_o,
  output ugpr_pkg::ugpr_unit_sts_t sts_o
);
  import ugpr_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo_q, quo_d, rem_q, rem_d, div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [WIDTH:0]   rem_sh, diff;
  logic             ge;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[WIDTH-1]};
    diff   = rem_sh - {1'b0, div_q};
    ge     = !diff[WIDTH];
    rem_d  = ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    quo_d  = {quo_q[WIDTH-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
endmodule

// ----- rtl/ugpr_scaler.sv -----
// Bit-serial exact floor(off * mag / dur) for off < dur, one bit of mag per cycle.
// Depends on ugpr_pkg for the unit status struct.
module ugpr_scaler #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [TIME_WIDTH-1:0]    off_i,
  input  logic [COORD_WIDTH-1:0]   mag_i,
  input  logic [TIME_WIDTH-1:0]    dur_i,
  output logic [COORD_WIDTH-1:0]   q_o,
  output ugpr_pkg::ugpr_unit_sts_t sts_o
);
  import ugpr_pkg::*;

  localparam int unsigned CntW = $clog2(COORD_WIDTH + 1);

  logic [TIME_WIDTH-1:0]  u_q, d_q, r_q, r_a, r_d;
  logic [COORD_WIDTH-1:0] m_q, q_q, q_a, q_d;
  logic [TIME_WIDTH:0]    r2, sum;
  logic                   dbl_ge, add_ge;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, done_q;

  // double the remainder modulo dur, then add off modulo dur if the bit is set
  always_comb begin
    r2     = {r_q, 1'b0};
    dbl_ge = r2 >= {1'b0, d_q};
    r_a    = dbl_ge ? TIME_WIDTH'(r2 - {1'b0, d_q}) : r2[TIME_WIDTH-1:0];
    q_a    = {q_q[COORD_WIDTH-2:0], dbl_ge};
    sum    = {1'b0, r_a} + {1'b0, u_q};
    add_ge = m_q[COORD_WIDTH-1] && (sum >= {1'b0, d_q});
    if (m_q[COORD_WIDTH-1]) begin
      r_d = add_ge ? TIME_WIDTH'(sum - {1'b0, d_q}) : sum[TIME_WIDTH-1:0];
    end else begin
      r_d = r_a;
    end
    q_d = q_a + COORD_WIDTH'(add_ge);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(COORD_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= off_i;
      d_q <= dur_i;
      m_q <= mag_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      q_q <= q_d;
      m_q <= {m_q[COORD_WIDTH-2:0], 1'b0};
    end
  end

  assign q_o        = q_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
endmodule

// ----- rtl/uniform_grid_path_resampler.sv -----
// Top level of the uniform grid path resampler.
// Depends on ugpr_pkg, ugpr_point_if, ugpr_sample_if, ugpr_divider, ugpr_scaler.
//
// Usage: points (x, y, time, path_start) arrive on point_i, resampled grid
// points leave on sample_o; both are valid/ready channels and a transaction
// completes when valid and ready are high at a rising clk_i edge. grid_step is
// written through grid_step_we_i/grid_step_i while the block is idle.
// One point is processed at a time. A point that starts a path, or emits no
// sample, leaves the sequencer idle. A point that emits N samples first runs
// the serial divider (grid count and remainder), then, for each sample, the two
// bit-serial interpolation scalers (x and y run side by side). Results sit in
// an output register, so the next point is accepted while the last sample
// still waits; a stalled receiver holds the sequencer in its emit step once
// the output register is full. Reset (rst_ni low, asynchronous) forgets the
// previous point, empties the output register and sets grid_step to 1.0 in
// Q16.16.
module uniform_grid_path_resampler #(
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned TIME_WIDTH   = 32,
  parameter int unsigned MAX_PER_ITEM = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         grid_step_we_i,
  input  logic [31:0]  grid_step_i,
  ugpr_point_if.sink   point_i,
  ugpr_sample_if.source sample_o
);
  import ugpr_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_PER_ITEM + 1);
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned TW   = TIME_WIDTH;

  ugpr_state_e state_q, state_d;

  logic [31:0]         grid_step_q;
  logic [TW-1:0]       step;
  logic signed [CW-1:0] prev_x_q, prev_y_q, seg_x0_q, seg_y0_q;
  logic [TW-1:0]       prev_t_q, next_grid_q, seg_t0_q, seg_t1_q, dur_q, g_q, g_d;
  logic                have_q, ended_q;
  logic [CW-1:0]       mag_x_q, mag_y_q;
  logic                neg_x_q, neg_y_q;
  logic [CntW-1:0]     cnt_q, emit_q;
  logic                trunc_q;

  logic                out_valid_q, out_last_q, out_trunc_q;
  logic signed [CW-1:0] out_x_q, out_y_q;
  logic [TW-1:0]       out_t_q;

  logic                in_acc, restart, seg_go, slot_free, load, last, sc_start;
  logic [CW:0]         dx, dy;
  logic [TW-1:0]       quo, rem, pad;
  logic [TW:0]         grid_sum;
  logic [CW-1:0]       qx, qy;
  ugpr_unit_sts_t      div_sts, scx_sts, scy_sts;

  // zero step behaves as a step of one
  assign step = (TW'(grid_step_q) == '0) ? TW'(1) : TW'(grid_step_q);

  // input decode
  assign in_acc  = point_i.valid && point_i.ready;
  assign restart = point_i.path_start || !have_q || (point_i.point_time < prev_t_q);
  assign seg_go  = !restart && !ended_q && (next_grid_q < point_i.point_time);
  assign dx = {point_i.point_x[CW-1], point_i.point_x} - {prev_x_q[CW-1], prev_x_q};
  assign dy = {point_i.point_y[CW-1], point_i.point_y} - {prev_y_q[CW-1], prev_y_q};
  assign point_i.ready = (state_q == ST_IDLE);

  // output register handshake
  assign slot_free = !out_valid_q || sample_o.ready;
  assign load      = (state_q == ST_EMIT) && slot_free;
  assign last      = (CntW'(cnt_q + CntW'(1)) == emit_q);
  assign sc_start  = ((state_q == ST_DIV) && div_sts.done) || (load && !last);

  // grid time of the sample the scalers work on next
  always_comb begin
    g_d = g_q;
    if (in_acc) begin
      g_d = next_grid_q;
    end else if (load) begin
      g_d = g_q + step;
    end
  end

  // grid resume point after this segment
  assign pad      = step - TW'(1) - rem;
  assign grid_sum = {1'b0, seg_t1_q} + {1'b0, pad};

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && seg_go) state_d = ST_DIV;
      ST_DIV:  if (div_sts.done) state_d = ST_MUL;
      ST_MUL:  if (scx_sts.done) state_d = ST_EMIT;
      ST_EMIT: if (load) state_d = last ? ST_IDLE : ST_MUL;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_step_q <= 32'd65536;
      have_q      <= 1'b0;
      ended_q     <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_t_q    <= '0;
      next_grid_q <= '0;
      cnt_q       <= '0;
      emit_q      <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (grid_step_we_i) begin
        grid_step_q <= grid_step_i;
      end
      // point acceptance
      if (in_acc) begin
        prev_x_q <= point_i.point_x;
        prev_y_q <= point_i.point_y;
        prev_t_q <= point_i.point_time;
        if (restart) begin
          next_grid_q <= point_i.point_time;
          ended_q     <= 1'b0;
          have_q      <= 1'b1;
        end
      end
      // grid count known: sample count, cap flag, grid resume time
      if ((state_q == ST_DIV) && div_sts.done) begin
        cnt_q <= '0;
        if (quo >= TW'(MAX_PER_ITEM)) begin
          emit_q  <= CntW'(MAX_PER_ITEM);
          trunc_q <= 1'b1;
        end else begin
          emit_q  <= CntW'(quo) + CntW'(1);
          trunc_q <= 1'b0;
        end
        if (grid_sum[TW]) begin
          ended_q <= 1'b1;
        end else begin
          next_grid_q <= grid_sum[TW-1:0];
        end
      end
      if (load) begin
        cnt_q <= CntW'(cnt_q + CntW'(1));
      end
      // output valid
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (sample_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // segment and output payload
  always_ff @(posedge clk_i) begin
    g_q <= g_d;
    if (in_acc) begin
      seg_x0_q <= prev_x_q;
      seg_y0_q <= prev_y_q;
      seg_t0_q <= prev_t_q;
      seg_t1_q <= point_i.point_time;
      dur_q    <= point_i.point_time - prev_t_q;
      neg_x_q  <= dx[CW];
      neg_y_q  <= dy[CW];
      mag_x_q  <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
      mag_y_q  <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
    end
    if (load) begin
      out_x_q     <= neg_x_q ? seg_x0_q - $signed(qx) : seg_x0_q + $signed(qx);
      out_y_q     <= neg_y_q ? seg_y0_q - $signed(qy) : seg_y0_q + $signed(qy);
      out_t_q     <= g_q;
      out_last_q  <= last;
      out_trunc_q <= trunc_q;
    end
  end

  // grid count and remainder of the segment
  ugpr_divider #(.WIDTH(TW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && seg_go),
    .dividend_i (point_i.point_time - next_grid_q - TW'(1)),
    .divisor_i  (step),
    .quotient_o (quo),
    .remainder_o(rem),
    .sts_o      (div_sts)
  );

  // interpolation offsets for x and y
  ugpr_scaler #(.TIME_WIDTH(TW), .COORD_WIDTH(CW)) u_scx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sc_start),
    .off_i  (g_d - seg_t0_q),
    .mag_i  (mag_x_q),
    .dur_i  (dur_q),
    .q_o    (qx),
    .sts_o  (scx_sts)
  );

  ugpr_scaler #(.TIME_WIDTH(TW), .COORD_WIDTH(CW)) u_scy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sc_start),
    .off_i  (g_d - seg_t0_q),
    .mag_i  (mag_y_q),
    .dur_i  (dur_q),
    .q_o    (qy),
    .sts_o  (scy_sts)
  );

  assign sample_o.valid       = out_valid_q;
  assign sample_o.sample_x    = out_x_q;
  assign sample_o.sample_y    = out_y_q;
  assign sample_o.sample_time = out_t_q;
  assign sample_o.last_of_run = out_last_q;
  assign sample_o.truncated   = out_trunc_q;

  // checks
  `ASSERT_PROP(a_div_done_in_div, clk_i, rst_ni, div_sts.done |-> state_q == ST_DIV, "div done")
  `ASSERT_PROP(a_scalers_lockstep, clk_i, rst_ni, scx_sts.busy == scy_sts.busy, "scaler step")
  `ASSERT_NEVER(a_cnt_cap, clk_i, rst_ni, ((state_q == ST_MUL) || (state_q == ST_EMIT)) && (cnt_q >= CntW'(MAX_PER_ITEM)), "cap")
  `ASSERT_PROP(a_valid_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_EMIT), "emit")
endmodule

// ----- tb/tb_pkg.sv -----
// Testbench types for the uniform grid path resampler bench.
// No dependencies; used by the testbench top module.
`timescale 1ns / 1ps
package tb_pkg;

  // One predicted grid sample
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [31:0]        st;
    logic               last;
    logic               trunc;
  } sample_t;

endpackage

// ----- tb/testbench.sv -----
// Self-checking bench for uniform_grid_path_resampler: random and directed points,
// predicted samples checked in order. Depends on tb_pkg and the RTL with its interfaces.
`timescale 1ns / 1ps
module testbench;
  import tb_pkg::*;

  localparam int unsigned CAP = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        grid_step_we_i = 1'b0;
  logic [31:0] grid_step_i = '0;

  ugpr_point_if  pt_if ();
  ugpr_sample_if sm_if ();

  uniform_grid_path_resampler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .grid_step_we_i(grid_step_we_i), .grid_step_i(grid_step_i),
    .point_i(pt_if.sink), .sample_o(sm_if.source)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] step_r;
  logic [31:0] px, py, pt, ngt;
  logic        have_prev, grid_done;
  sample_t     pending_q[$];
  int          errors = 0;
  bit          quiet = 1'b0;

  // floor(off * |delta| / dur), exact with 65-bit product
  function automatic logic [31:0] lerp(logic [31:0] p, logic [31:0] c,
                                       logic [31:0] off, logic [31:0] dur);
    logic [32:0] mag;
    logic [64:0] prod;
    logic [64:0] q;
    mag = ($signed(c) >= $signed(p)) ? 33'($signed({c[31], c}) - $signed({p[31], p}))
                                     : 33'($signed({p[31], p}) - $signed({c[31], c}));
    prod = 65'(mag) * 65'(off);
    q = prod / 65'(dur);
    return ($signed(c) >= $signed(p)) ? p + q[31:0] : p - q[31:0];
  endfunction

  // Work out the samples caused by one point
  task automatic predict_samples(logic [31:0] x, logic [31:0] y, logic [31:0] t, logic st);
    logic [63:0] stp, g, span1, extra, pad, emit, k;
    logic        tr;
    sample_t     s;
    if (st || !have_prev || t < pt) begin
      px = x; py = y; pt = t; ngt = t; grid_done = 0; have_prev = 1;
      return;
    end
    if (!grid_done && ngt < t) begin
      stp = (step_r == 0) ? 64'd1 : 64'(step_r);
      g = 64'(ngt);
      span1 = 64'(t) - g - 1;
      extra = span1 / stp;
      pad = stp - 1 - (span1 % stp);
      tr = extra >= CAP;
      emit = tr ? CAP : extra + 1;
      if (pad > 64'hFFFF_FFFF - 64'(t)) grid_done = 1;
      else ngt = t + pad[31:0];
      for (k = 0; k < emit; k++) begin
        s.sx = lerp(px, x, g[31:0] - pt, t - pt);
        s.sy = lerp(py, y, g[31:0] - pt, t - pt);
        s.st = g[31:0];
        s.last = (k + 1 == emit);
        s.trunc = tr;
        pending_q.push_back(s);
        g += stp;
      end
    end
    px = x; py = y; pt = t;
  endtask

  // Receiver: random stall bursts unless quiet, checks each transaction
  initial begin
    int stall_n;
    stall_n = 0;
    sm_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sm_if.valid && sm_if.ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected sample x=%h y=%h t=%h", $time, sm_if.sample_x,
                   sm_if.sample_y, sm_if.sample_time);
          errors++;
        end else begin
          sample_t e;
          e = pending_q.pop_front();
          if (sm_if.sample_x !== e.sx || sm_if.sample_y !== e.sy ||
              sm_if.sample_time !== e.st || sm_if.last_of_run !== e.last ||
              sm_if.truncated !== e.trunc) begin
            $display("%0t: mismatch expected x=%h y=%h t=%h l=%b tr=%b", $time,
                     e.sx, e.sy, e.st, e.last, e.trunc);
            $display("%0t:          actual   x=%h y=%h t=%h l=%b tr=%b", $time,
                     sm_if.sample_x, sm_if.sample_y, sm_if.sample_time,
                     sm_if.last_of_run, sm_if.truncated);
            errors++;
          end
        end
      end
      if (stall_n > 0) begin
        sm_if.ready <= 1'b0;
        stall_n--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        sm_if.ready <= 1'b0;
        stall_n = $urandom_range(0, 3);
      end else begin
        sm_if.ready <= 1'b1;
      end
    end
  end

  // Send one point; random idle bursts before some transactions unless quiet
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] t, logic st);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    pt_if.valid <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    pt_if.point_time <= t;
    pt_if.path_start <= st;
    predict_samples(x, y, t, st);
    do @(posedge clk_i); while (!pt_if.ready);
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_step(logic [31:0] v);
    drain();
    grid_step_we_i <= 1'b1;
    grid_step_i <= v;
    step_r = v;
    @(posedge clk_i);
    grid_step_we_i <= 1'b0;
  endtask

  // Directed: extremes, backwards time, equal times, cap, overflow
  task automatic test_directed();
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 1);
    send_point(32'h0005_0000, 32'hFFFE_0000, 32'h0004_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0004_0000, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0007_8000, 0);
    send_point(32'h1234_0000, 32'h0, 32'h0002_0000, 0);
    send_point(32'h0, 32'h0, 32'h0080_0000, 0);
    write_step(32'h0);
    send_point(32'h0, 32'h0, 32'h0000_0010, 1);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0020, 0);
    write_step(32'hFFFF_FFFF);
    send_point(32'h0, 32'h0, 32'h0000_0005, 1);
    send_point(32'h0100_0000, 32'h0, 32'hFFFF_FFFF, 0);
    send_point(32'h0200_0000, 32'h1, 32'hFFFF_FFFF, 0);
    write_step(32'h0000_8000);
    send_point(32'h0, 32'h0, 32'hFFFE_0000, 1);
    send_point(32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 0);
    send_point(32'h0002_0000, 32'h0, 32'hFFFF_FFFF, 0);
    write_step(32'h0001_0000);
  endtask

  // Random paths; mostly well-formed rising times
  task automatic test_random_paths(int n_points);
    logic [31:0] t;
    int i;
    t = 0;
    for (i = 0; i < n_points; i++) begin
      logic st;
      logic [31:0] dt;
      st = (i == 0) || ($urandom_range(0, 19) == 0);
      case ($urandom_range(0, 9))
        0: dt = 0;
        1: dt = $urandom;
        2: dt = $urandom_range(1, 40) * step_r;
        default: dt = $urandom_range(0, 4 * (step_r > 32'h4_0000 ? 32'h4_0000 : step_r));
      endcase
      if (st) t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h100_0000);
      else if ($urandom_range(0, 29) == 0) t = t - $urandom_range(1, 1000);
      else t = (64'(t) + dt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t + dt;
      send_point($urandom, $urandom, t, st);
    end
  endtask

  task automatic test_pause_until_empty();
    drain();
    send_point(32'h0, 32'h0, 32'h10_0000, 1);
    send_point(32'h3_0000, 32'hFFFD_0000, 32'h14_0000, 0);
  endtask

  initial begin
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_time = '0;
    pt_if.path_start = 1'b0;
    step_r = 32'h0001_0000;
    px = 0; py = 0; pt = 0; ngt = 0; have_prev = 0; grid_done = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_paths(80);
    write_step(32'h0000_4000);
    test_random_paths(60);
    test_pause_until_empty();
    write_step(32'h0003_0000);
    test_random_paths(60);
    write_step(32'h0001_0000);
    quiet = 1'b1;
    test_random_paths(50);
    drain();
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // Run limit
  initial begin
    #200ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
